>>> hdl/stereo_resample_mixer_core_macros.svh
// assertion macros used by the checker file
`ifndef STEREO_RESAMPLE_MIXER_CORE_MACROS_SVH
`define STEREO_RESAMPLE_MIXER_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define SMIX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smix assertion failed");

// next-cycle implication, off while reset is low
`define SMIX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smix assertion failed");

`endif

>>> hdl/smix_pkg.sv
package smix_pkg;

  localparam int unsigned PHASE_FRAC_BITS_DEF = 16;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned PEND_W   = 4;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd60211;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 8'd255;
  localparam logic [PEND_W-1:0] PEND_MAX   = 4'd15;
  localparam logic [PEND_W-1:0] PEND_START = 4'd2;

  // x/255 for x < 2^23 as (x*32897)>>23, at most one too high
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_MIX   = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_PHASE_STEP = 1'b0,
    REG_VOLUME     = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LANE = 2'd1,
    ST_DONE = 2'd2
  } st_e;

  typedef struct packed {
    logic              play;
    logic              cur_ok;
    logic              nxt_ok;
    logic [PEND_W-1:0] pending;
  } flags_t;

  function automatic logic mix_active(flags_t f);
    return f.play && (f.pending == '0) && f.cur_ok;
  endfunction

endpackage

>>> hdl/stereo_resample_mixer_core.sv
// channel   direction  handshake                      payload
// in        input      in_valid_i / in_stall_o        command, src_left/right, src_valid,
//                                                     mix_left/right
// out       output     out_valid_o / out_stall_i      out_left/right, frames_needed,
//                                                     is_playing
// cfg       input      cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// a mix request with playback active goes from accept to result through
// the six-stage lane pipeline (interpolate, scale, divide by 255, saturate) and commit
// load, start and inactive mix requests skip the lanes and go from accept straight to commit
// one request in flight at a time; the port reopens the cycle after commit, so a
// request can start only once the one before it has committed
// a finished result sits in the output register, so a stalled output holds one
// result while the next request runs; reset is asynchronous and clears all but the data registers
module stereo_resample_mixer_core #(
  parameter int unsigned PHASE_FRAC_BITS = smix_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic signed [15:0]           src_left_i,
  input  logic signed [15:0]           src_right_i,
  input  logic                         src_valid_i,
  input  logic signed [15:0]           mix_left_i,
  input  logic signed [15:0]           mix_right_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           out_left_o,
  output logic signed [15:0]           out_right_o,
  output logic [smix_pkg::PEND_W-1:0]  frames_needed_o,
  output logic                         is_playing_o,
  // register writes
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [smix_pkg::STEP_W-1:0]  cfg_data_i
);

  // control state
  smix_pkg::st_e                st_q, st_d;
  smix_pkg::flags_t             flags_q, flags_d;
  logic [PHASE_FRAC_BITS-1:0]   phase_q, phase_d;
  logic [smix_pkg::FRAME_W-1:0] cur_q, cur_d;
  logic [smix_pkg::FRAME_W-1:0] nxt_q, nxt_d;

  // configuration registers
  logic [smix_pkg::STEP_W-1:0]  step_q;
  logic [smix_pkg::VOL_W-1:0]   vol_q;

  // captured request
  logic [1:0]                   cmd_q;
  logic signed [15:0]           src_left_q;
  logic signed [15:0]           src_right_q;
  logic                         src_valid_q;
  logic signed [15:0]           mix_left_q;
  logic signed [15:0]           mix_right_q;

  // output register
  logic                         out_valid_q;
  logic signed [15:0]           out_left_q;
  logic signed [15:0]           out_right_q;
  logic [smix_pkg::PEND_W-1:0]  frames_q;
  logic                         playing_q;

  logic                         in_accept;
  logic                         lane_start;
  logic                         commit;
  logic                         out_free;

  logic signed [15:0]           lane_cur_l, lane_cur_r;
  logic signed [15:0]           lane_nxt_l, lane_nxt_r;
  logic                         done_l, done_r;
  logic signed [15:0]           res_l, res_r;
  logic signed [15:0]           merge_left, merge_right;

  assign in_stall_o = (st_q != smix_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencer: accept, run lanes when a real mix is due, then commit
  always_comb begin
    st_d       = st_q;
    lane_start = 1'b0;
    commit     = 1'b0;
    case (st_q)
      smix_pkg::ST_IDLE: begin
        if (in_accept) begin
          if ((command_i == smix_pkg::CMD_MIX) && smix_pkg::mix_active(flags_q)) begin
            lane_start = 1'b1;
            st_d       = smix_pkg::ST_LANE;
          end else begin
            st_d = smix_pkg::ST_DONE;
          end
        end
      end
      smix_pkg::ST_LANE: begin
        if (done_l && done_r) st_d = smix_pkg::ST_DONE;
      end
      smix_pkg::ST_DONE: begin
        // result waits here only while the output register is still full and stalled
        if (out_free) begin
          commit = 1'b1;
          st_d   = smix_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = smix_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smix_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // capture the request payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q       <= command_i;
      src_left_q  <= src_left_i;
      src_right_q <= src_right_i;
      src_valid_q <= src_valid_i;
      mix_left_q  <= mix_left_i;
      mix_right_q <= mix_right_i;
    end
  end

  // register writes, only while idle: the user must keep to this, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= smix_pkg::STEP_RESET;
      vol_q  <= smix_pkg::VOL_RESET;
    end else if (cfg_we_i) begin
      case (smix_pkg::reg_e'(cfg_index_i))
        smix_pkg::REG_PHASE_STEP: step_q <= cfg_data_i;
        smix_pkg::REG_VOLUME:     vol_q  <= cfg_data_i[smix_pkg::VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frames hold left in the low half; with no next frame the current one is held flat
  assign lane_cur_l = $signed(cur_q[15:0]);
  assign lane_cur_r = $signed(cur_q[31:16]);
  assign lane_nxt_l = flags_q.nxt_ok ? $signed(nxt_q[15:0])  : lane_cur_l;
  assign lane_nxt_r = flags_q.nxt_ok ? $signed(nxt_q[31:16]) : lane_cur_r;

  // one lane per channel side; base samples come straight off the request port
  smix_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .cur_i   (lane_cur_l),
    .nxt_i   (lane_nxt_l),
    .base_i  (mix_left_i),
    .frac_i  (phase_q),
    .vol_i   (vol_q),
    .done_o  (done_l),
    .res_o   (res_l)
  );

  smix_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .cur_i   (lane_cur_r),
    .nxt_i   (lane_nxt_r),
    .base_i  (mix_right_i),
    .frac_i  (phase_q),
    .vol_i   (vol_q),
    .done_o  (done_r),
    .res_o   (res_r)
  );

  // merge: playback state update and the result fields
  smix_merge #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_merge (
    .flags_i      (flags_q),
    .cur_i        (cur_q),
    .nxt_i        (nxt_q),
    .phase_i      (phase_q),
    .step_i       (step_q),
    .cmd_i        (cmd_q),
    .src_left_i   (src_left_q),
    .src_right_i  (src_right_q),
    .src_valid_i  (src_valid_q),
    .mix_left_i   (mix_left_q),
    .mix_right_i  (mix_right_q),
    .lane_left_i  (res_l),
    .lane_right_i (res_r),
    .flags_o      (flags_d),
    .cur_o        (cur_d),
    .nxt_o        (nxt_d),
    .phase_o      (phase_d),
    .out_left_o   (merge_left),
    .out_right_o  (merge_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      phase_q <= '0;
      cur_q   <= '0;
      nxt_q   <= '0;
    end else if (commit) begin
      flags_q <= flags_d;
      phase_q <= phase_d;
      cur_q   <= cur_d;
      nxt_q   <= nxt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_left_q  <= merge_left;
      out_right_q <= merge_right;
      frames_q    <= flags_d.pending;
      playing_q   <= flags_d.play;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_left_o      = out_left_q;
  assign out_right_o     = out_right_q;
  assign frames_needed_o = frames_q;
  assign is_playing_o    = playing_q;

endmodule

>>> hdl/smix_lane.sv
module smix_lane #(
  parameter int unsigned PHASE_FRAC_BITS = smix_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [15:0]          cur_i,
  input  logic signed [15:0]          nxt_i,
  input  logic signed [15:0]          base_i,
  input  logic [PHASE_FRAC_BITS-1:0]  frac_i,
  input  logic [smix_pkg::VOL_W-1:0]  vol_i,
  output logic                        done_o,
  output logic signed [15:0]          res_o
);

  localparam int unsigned STAGES = 6;
  localparam int unsigned PROD_W = smix_pkg::SAMPLE_W + PHASE_FRAC_BITS;
  localparam int unsigned MAG_W  = 23;
  localparam int unsigned RECP_W = MAG_W + 16;
  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  logic [STAGES-1:0] vld_q;

  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [15:0]        mag_q;
  logic               neg_q;
  logic signed [15:0] cur_q;
  logic signed [15:0] base_q;

  logic [PROD_W-1:0]  frac_prod;
  logic [15:0]        part_q;

  logic signed [17:0] s_val;
  logic signed [26:0] sv_full;
  logic signed [24:0] sv_q;

  logic [24:0]        sv_abs;
  logic [MAG_W-1:0]   m_q;
  logic               sneg_q;
  logic [RECP_W-1:0]  recp_q;

  logic [15:0]        q_est;
  logic [23:0]        q_back;
  logic [15:0]        q_q;

  logic signed [17:0] q_signed;
  logic signed [17:0] sum_t;
  logic signed [15:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], start_i};
    end
  end

  // stage 0: difference and its magnitude
  assign diff     = $signed({nxt_i[15], nxt_i}) - $signed({cur_i[15], cur_i});
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= diff_abs[15:0];
      neg_q  <= diff[16];
      cur_q  <= cur_i;
      base_q <= base_i;
    end
  end

  // stage 1: magnitude times phase fraction
  assign frac_prod = PROD_W'(mag_q) * PROD_W'(frac_i);

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      part_q <= frac_prod[PHASE_FRAC_BITS +: 16];
    end
  end

  // stage 2: interpolated sample times volume
  assign s_val   = $signed({{2{cur_q[15]}}, cur_q})
                 + (neg_q ? -$signed({2'b00, part_q}) : $signed({2'b00, part_q}));
  assign sv_full = 27'(s_val) * 27'($signed({1'b0, vol_i}));

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      sv_q <= sv_full[24:0];
    end
  end

  // stage 3: reciprocal multiply on the magnitude
  assign sv_abs = sv_q[24] ? 25'(-sv_q) : 25'(sv_q);

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      m_q    <= sv_abs[MAG_W-1:0];
      sneg_q <= sv_q[24];
      recp_q <= RECP_W'(sv_abs[MAG_W-1:0]) * RECP_W'(smix_pkg::DIV255_RECIP);
    end
  end

  // stage 4: fix up the quotient estimate
  assign q_est  = recp_q[smix_pkg::DIV255_SHIFT +: 16];
  assign q_back = {q_est, 8'h00} - {8'h00, q_est};

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      q_q <= (q_back > {1'b0, m_q}) ? (q_est - 16'd1) : q_est;
    end
  end

  // stage 5: restore sign, add onto mix sample, saturate
  assign q_signed = sneg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
  assign sum_t    = $signed({{2{base_q[15]}}, base_q}) + q_signed;

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      if (sum_t > SAT_MAX) begin
        res_q <= SAT_MAX[15:0];
      end else if (sum_t < SAT_MIN) begin
        res_q <= SAT_MIN[15:0];
      end else begin
        res_q <= sum_t[15:0];
      end
    end
  end

  assign done_o = vld_q[STAGES-1];
  assign res_o  = res_q;

endmodule

>>> hdl/smix_merge.sv
module smix_merge #(
  parameter int unsigned PHASE_FRAC_BITS = smix_pkg::PHASE_FRAC_BITS_DEF
) (
  input  smix_pkg::flags_t                  flags_i,
  input  logic [smix_pkg::FRAME_W-1:0]      cur_i,
  input  logic [smix_pkg::FRAME_W-1:0]      nxt_i,
  input  logic [PHASE_FRAC_BITS-1:0]        phase_i,
  input  logic [smix_pkg::STEP_W-1:0]       step_i,
  input  logic [1:0]                        cmd_i,
  input  logic signed [15:0]                src_left_i,
  input  logic signed [15:0]                src_right_i,
  input  logic                              src_valid_i,
  input  logic signed [15:0]                mix_left_i,
  input  logic signed [15:0]                mix_right_i,
  input  logic signed [15:0]                lane_left_i,
  input  logic signed [15:0]                lane_right_i,
  output smix_pkg::flags_t                  flags_o,
  output logic [smix_pkg::FRAME_W-1:0]      cur_o,
  output logic [smix_pkg::FRAME_W-1:0]      nxt_o,
  output logic [PHASE_FRAC_BITS-1:0]        phase_o,
  output logic signed [15:0]                out_left_o,
  output logic signed [15:0]                out_right_o
);

  localparam int unsigned SUM_W =
    ((PHASE_FRAC_BITS > smix_pkg::STEP_W) ? PHASE_FRAC_BITS : smix_pkg::STEP_W) + 1;
  localparam int unsigned WHOLE_W  = SUM_W - PHASE_FRAC_BITS;
  localparam int unsigned WHOLE_XW =
    (WHOLE_W > smix_pkg::PEND_W) ? WHOLE_W : smix_pkg::PEND_W;

  logic [SUM_W-1:0]              sum;
  logic [WHOLE_XW-1:0]           whole;
  logic [smix_pkg::PEND_W-1:0]   pend_dec;
  logic [smix_pkg::FRAME_W-1:0]  src_frame;

  assign sum       = SUM_W'(phase_i) + SUM_W'(step_i);
  assign whole     = WHOLE_XW'(sum[SUM_W-1:PHASE_FRAC_BITS]);
  assign pend_dec  = flags_i.pending - 4'd1;
  assign src_frame = {src_right_i, src_left_i};

  always_comb begin
    flags_o     = flags_i;
    cur_o       = cur_i;
    nxt_o       = nxt_i;
    phase_o     = phase_i;
    out_left_o  = mix_left_i;
    out_right_o = mix_right_i;
    case (smix_pkg::cmd_e'(cmd_i))
      smix_pkg::CMD_START: begin
        flags_o.play    = 1'b1;
        flags_o.cur_ok  = 1'b0;
        flags_o.nxt_ok  = 1'b0;
        flags_o.pending = smix_pkg::PEND_START;
        phase_o         = '0;
      end
      smix_pkg::CMD_LOAD: begin
        if (flags_i.pending != '0) begin
          flags_o.pending = pend_dec;
          if (!flags_i.cur_ok) begin
            // priming the current frame
            if (src_valid_i) begin
              cur_o          = src_frame;
              flags_o.cur_ok = 1'b1;
            end else begin
              flags_o.play    = 1'b0;
              flags_o.pending = '0;
            end
          end else if (!flags_i.nxt_ok) begin
            if (src_valid_i) nxt_o = src_frame;
            flags_o.nxt_ok = src_valid_i;
          end else begin
            // crossing: shift next into current
            cur_o = nxt_i;
            if (src_valid_i) nxt_o = src_frame;
            flags_o.nxt_ok = src_valid_i;
            if (!src_valid_i && (pend_dec != '0)) begin
              flags_o.play    = 1'b0;
              flags_o.pending = '0;
            end
          end
        end
      end
      smix_pkg::CMD_MIX: begin
        if (smix_pkg::mix_active(flags_i)) begin
          out_left_o  = lane_left_i;
          out_right_o = lane_right_i;
          phase_o     = sum[PHASE_FRAC_BITS-1:0];
          if (whole != '0) begin
            if (!flags_i.nxt_ok) begin
              flags_o.play    = 1'b0;
              flags_o.pending = '0;
            end else if (whole > WHOLE_XW'(smix_pkg::PEND_MAX)) begin
              flags_o.pending = smix_pkg::PEND_MAX;
            end else begin
              flags_o.pending = whole[smix_pkg::PEND_W-1:0];
            end
          end
        end
      end
      smix_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/smix_checker.sv
`include "stereo_resample_mixer_core_macros.svh"

module smix_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [15:0]           out_left_o,
  input logic signed [15:0]           out_right_o,
  input logic [smix_pkg::PEND_W-1:0]  frames_needed_o,
  input logic                         is_playing_o
);

  // a stalled result stays offered
  `SMIX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its samples
  `SMIX_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable({out_left_o, out_right_o}))

  // one request in flight: the port closes right after an accept
  `SMIX_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // stopped playback never asks for frames
  `SMIX_ASSERT_SAME(a_stop_no_loads, clk_i, rst_ni, out_valid_o && !is_playing_o, frames_needed_o == '0)

endmodule

bind stereo_resample_mixer_core smix_checker u_smix_checker (.*);
